FILE: src/conv2d_pkg.sv
// Shared constants and control types for the zero-padded 2D convolution core.
package conv2d_pkg;

  localparam int MAX_DIM    = 64;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int SIZE_W     = DIM_W + 1;
  localparam int IMG_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int IMG_AW     = 2 * DIM_W;

  localparam int MAX_KERNEL = 7;
  localparam int KER_W      = 3;
  localparam int KER_DEPTH  = MAX_KERNEL * MAX_KERNEL;
  localparam int KER_AW     = $clog2(KER_DEPTH);

  localparam int VAL_W      = 16;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int ACC_W      = 44;
  localparam int FRAC_W     = 8;
  localparam int SUM_W      = 32;
  localparam int IDX_W      = DIM_W + 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_PIXEL  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 2'd3;

  typedef struct packed {
    logic             load_query;
    logic             issue;
    logic [KER_W-1:0] mm;
    logic [KER_W-1:0] nn;
    logic             finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KER_W-1:0] kr;
    logic [KER_W-1:0] kc;
  } dp_stat_t;

endpackage

FILE: src/conv2d_ctrl.sv
// Controller: sequences the kernel taps of a query and flushes the MAC pipeline.
module conv2d_ctrl
  import conv2d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      query_go,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [KER_W-1:0] mm, mm_next;
  logic [KER_W-1:0] nn, nn_next;
  logic             drain_cnt, drain_cnt_next;

  always_comb begin
    state_next     = state;
    mm_next        = mm;
    nn_next        = nn;
    drain_cnt_next = drain_cnt;
    case (state)
      S_IDLE: begin
        if (query_go) begin
          state_next = S_RUN;
          mm_next    = '0;
          nn_next    = '0;
        end
      end
      S_RUN: begin
        if (nn == stat.kc - KER_W'(1)) begin
          nn_next = '0;
          if (mm == stat.kr - KER_W'(1)) begin
            state_next     = S_DRAIN;
            drain_cnt_next = 1'b0;
          end else begin
            mm_next = mm + KER_W'(1);
          end
        end else begin
          nn_next = nn + KER_W'(1);
        end
      end
      S_DRAIN: begin
        // drain: read data stage, then product stage into the accumulator
        drain_cnt_next = 1'b1;
        if (drain_cnt) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mm        <= '0;
      nn        <= '0;
      drain_cnt <= 1'b0;
    end else begin
      state     <= state_next;
      mm        <= mm_next;
      nn        <= nn_next;
      drain_cnt <= drain_cnt_next;
    end
  end

  always_comb begin
    cmd.load_query = (state == S_IDLE) && query_go;
    cmd.issue      = (state == S_RUN);
    cmd.mm         = mm;
    cmd.nn         = nn;
    cmd.finish     = (state == S_FIN);
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: src/conv2d_dp.sv
// Datapath: size registers, image and kernel memories, MAC pipeline, output stage.
module conv2d_dp
  import conv2d_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        item_ok,
  input  logic [1:0]                  req_type,
  input  logic [DIM_W-1:0]            row,
  input  logic [DIM_W-1:0]            col,
  input  logic signed [VAL_W-1:0]     value,
  input  ctrl_cmd_t                   cmd,
  output dp_stat_t                    stat,
  output logic signed [SUM_W-1:0]     conv_sum,
  output logic                        saturated,
  output logic                        done
);

  localparam int Q_W = ACC_W - FRAC_W;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(64'sd2147483647);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-64'sd2147483648);

  // sizes held already clamped to their legal ranges
  logic [SIZE_W-1:0] ir, ic;
  logic [KER_W-1:0]  kr, kc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir <= SIZE_W'(MAX_DIM);
      ic <= SIZE_W'(MAX_DIM);
      kr <= KER_W'(3);
      kc <= KER_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_ROWS: begin
          if (cfg_data == '0)                          ir <= SIZE_W'(1);
          else if (cfg_data > CFG_DATA_W'(MAX_DIM))    ir <= SIZE_W'(MAX_DIM);
          else                                         ir <= SIZE_W'(cfg_data);
        end
        CFG_IMAGE_COLS: begin
          if (cfg_data == '0)                          ic <= SIZE_W'(1);
          else if (cfg_data > CFG_DATA_W'(MAX_DIM))    ic <= SIZE_W'(MAX_DIM);
          else                                         ic <= SIZE_W'(cfg_data);
        end
        CFG_KERNEL_ROWS: begin
          if (cfg_data[KER_W-1:0] == '0) kr <= KER_W'(1);
          else                           kr <= cfg_data[KER_W-1:0];
        end
        CFG_KERNEL_COLS: begin
          if (cfg_data[KER_W-1:0] == '0) kc <= KER_W'(1);
          else                           kc <= cfg_data[KER_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign stat.kr = kr;
  assign stat.kc = kc;

  // write side of the stores
  logic              img_we, ker_we;
  logic [IMG_AW-1:0] img_waddr;
  logic [KER_AW-1:0] ker_waddr;

  assign img_we = item_ok && (req_type == REQ_PIXEL) &&
                  ({1'b0, row} < ir) && ({1'b0, col} < ic);
  assign ker_we = item_ok && (req_type == REQ_WEIGHT) &&
                  (row < DIM_W'(kr)) && (col < DIM_W'(kc));
  assign img_waddr = {row, col};
  assign ker_waddr = KER_AW'({row[KER_W-1:0], 3'b000}) - KER_AW'(row[KER_W-1:0]) +
                     KER_AW'(col[KER_W-1:0]);

  // tap address generation
  logic [DIM_W-1:0]        q_row, q_col;
  logic signed [IDX_W-1:0] ii, jj;
  logic                    tap_in;
  logic [IMG_AW-1:0]       img_raddr;
  logic [KER_AW-1:0]       ker_raddr;

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_row <= row;
      q_col <= col;
    end
  end

  assign ii = $signed({2'b00, q_row}) + $signed(IDX_W'(kr >> 1)) - $signed(IDX_W'(cmd.mm));
  assign jj = $signed({2'b00, q_col}) + $signed(IDX_W'(kc >> 1)) - $signed(IDX_W'(cmd.nn));
  assign tap_in = (ii >= 0) && (ii < $signed(IDX_W'(ir))) &&
                  (jj >= 0) && (jj < $signed(IDX_W'(ic)));
  assign img_raddr = {ii[DIM_W-1:0], jj[DIM_W-1:0]};
  assign ker_raddr = KER_AW'({cmd.mm, 3'b000}) - KER_AW'(cmd.mm) + KER_AW'(cmd.nn);

  // memories with registered read
  logic signed [VAL_W-1:0] img_mem [IMG_DEPTH];
  logic signed [VAL_W-1:0] ker_mem [KER_DEPTH];
  logic signed [VAL_W-1:0] img_rd, ker_rd;

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_waddr] <= value;
    end
    img_rd <= img_mem[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (ker_we) begin
      ker_mem[ker_waddr] <= value;
    end
    ker_rd <= ker_mem[ker_raddr];
  end

  // MAC pipeline: read data -> product -> accumulate
  logic                     v1, v2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue && tap_in;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= img_rd * ker_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // floor shift of the Q36.8 sum to an integer and clip to 32 bits
  logic signed [Q_W-1:0] q;
  assign q = Q_W'(acc >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (q > Q_MAX) begin
        conv_sum  <= Q_MAX[SUM_W-1:0];
        saturated <= 1'b1;
      end else if (q < Q_MIN) begin
        conv_sum  <= Q_MIN[SUM_W-1:0];
        saturated <= 1'b1;
      end else begin
        conv_sum  <= q[SUM_W-1:0];
        saturated <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

FILE: src/conv2d_zero_padded_core.sv
// Top level of the same-size zero-padded 2D convolution core.
//
// Command channel: a word (req_type, row, col, value) is taken at a clock
// edge where start is high and busy is low. A weight or pixel write is done
// at that edge and busy stays low, so writes go one per cycle. Writes whose
// row or col is outside the sizes in use are dropped.
// A query raises busy and walks the kernel taps, one per cycle through a
// single multiply-accumulate fed by the image and kernel memories. The
// result shows on conv_sum/saturated with done high for one cycle, after
// the last tap has passed the read data, product and accumulate stages;
// busy falls in that same cycle.
// There is no result backpressure: the receiver must take done words.
// Config channel: cfg_ready is always high; write sizes only while idle.
// Reset sets 64x64 image and 3x3 kernel sizes and clears control state;
// memory contents are not cleared and must be written before use.
module conv2d_zero_padded_core
  import conv2d_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              req_type,
  input  logic [DIM_W-1:0]        row,
  input  logic [DIM_W-1:0]        col,
  input  logic signed [VAL_W-1:0] value,
  output logic                    done,
  output logic signed [SUM_W-1:0] conv_sum,
  output logic                    saturated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      item_ok;
  logic      query_go;

  assign cfg_ready = 1'b1;
  assign item_ok   = start && !busy;
  assign query_go  = item_ok && (req_type == REQ_QUERY);

  conv2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .query_go (query_go),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  conv2d_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_ok   (item_ok),
    .req_type  (req_type),
    .row       (row),
    .col       (col),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .conv_sum  (conv_sum),
    .saturated (saturated),
    .done      (done)
  );

endmodule

FILE: sim/conv2d_zero_padded_core_tb.sv
// Testbench for conv2d_zero_padded_core: self-checking convolution queries under random traffic.
module conv2d_zero_padded_core_tb;
  import conv2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_NONE    = 2'd3;
  localparam int         IDLE_PCT    = 23;
  localparam int         DRAIN_WAIT  = 60;
  localparam longint     SUM_MAX     = 64'sd2147483647;
  localparam longint     SUM_MIN     = -SUM_MAX - 1;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    sat;
  } conv_word_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              req_type;
  logic [DIM_W-1:0]        row;
  logic [DIM_W-1:0]        col;
  logic signed [VAL_W-1:0] value;
  logic                    done;
  logic signed [SUM_W-1:0] conv_sum;
  logic                    saturated;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // shadow copy of the block: size registers and both memories
  logic [SIZE_W-1:0]       img_rows_reg;
  logic [SIZE_W-1:0]       img_cols_reg;
  logic [KER_W-1:0]        ker_rows_reg;
  logic [KER_W-1:0]        ker_cols_reg;
  logic signed [VAL_W-1:0] pixel_mem  [IMG_DEPTH];
  logic signed [VAL_W-1:0] weight_mem [KER_DEPTH];
  bit                      pixel_known  [IMG_DEPTH];
  bit                      weight_known [KER_DEPTH];

  conv_word_t pending_sums[$];
  int         mismatches = 0;
  int         words_sent = 0;
  bit         gaps_on    = 1'b1;

  conv2d_zero_padded_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .row       (row),
    .col       (col),
    .value     (value),
    .done      (done),
    .conv_sum  (conv_sum),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // size registers: 0 behaves as 1, anything above the maximum as the maximum
  function automatic int eff_dim(input int raw, input int maxv);
    if (raw == 0) return 1;
    return (raw > maxv) ? maxv : raw;
  endfunction

  function automatic int img_rows();
    return eff_dim(int'(img_rows_reg), MAX_DIM);
  endfunction

  function automatic int img_cols();
    return eff_dim(int'(img_cols_reg), MAX_DIM);
  endfunction

  function automatic int ker_rows();
    return eff_dim(int'(ker_rows_reg), MAX_KERNEL);
  endfunction

  function automatic int ker_cols();
    return eff_dim(int'(ker_cols_reg), MAX_KERNEL);
  endfunction

  // flipped, centred kernel; taps off the image are skipped
  function automatic conv_word_t conv_at(input int r, input int c);
    int         ir, ic, kr, kc, cy, cx, ii, jj;
    longint     acc;
    longint     q;
    conv_word_t res;
    ir  = img_rows();
    ic  = img_cols();
    kr  = ker_rows();
    kc  = ker_cols();
    cy  = kr / 2;
    cx  = kc / 2;
    acc = 0;
    for (int mm = 0; mm < kr; mm++) begin
      ii = r + cy - mm;
      if (ii >= 0 && ii < ir) begin
        for (int nn = 0; nn < kc; nn++) begin
          jj = c + cx - nn;
          if (jj >= 0 && jj < ic)
            acc += longint'(pixel_mem[ii * MAX_DIM + jj]) *
                   longint'(weight_mem[mm * MAX_KERNEL + nn]);
        end
      end
    end
    q = acc >>> FRAC_W;
    res.sat = 1'b0;
    if (q > SUM_MAX) begin
      q = SUM_MAX;
      res.sat = 1'b1;
    end else if (q < SUM_MIN) begin
      q = SUM_MIN;
      res.sat = 1'b1;
    end
    res.sum = q[SUM_W-1:0];
    return res;
  endfunction

  function automatic void absorb_word(input logic [1:0] kind, input int r, input int c,
                                      input logic signed [VAL_W-1:0] v);
    case (kind)
      REQ_WEIGHT: begin
        if (r < ker_rows() && c < ker_cols()) begin
          weight_mem[r * MAX_KERNEL + c]   = v;
          weight_known[r * MAX_KERNEL + c] = 1'b1;
        end
      end
      REQ_PIXEL: begin
        if (r < img_rows() && c < img_cols()) begin
          pixel_mem[r * MAX_DIM + c]   = v;
          pixel_known[r * MAX_DIM + c] = 1'b1;
        end
      end
      REQ_QUERY: pending_sums.push_back(conv_at(r, c));
      default: ;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'shFFFF;
      3: return VAL_W'($urandom_range(511));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // start stays high across back-to-back words; it drops during a gap and in settle()
  task automatic send_word(input logic [1:0] kind, input int r, input int c,
                           input logic signed [VAL_W-1:0] v);
    logic [DIM_W-1:0] rr;
    logic [DIM_W-1:0] cc;
    rr = DIM_W'(r);
    cc = DIM_W'(c);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= kind;
    row      <= rr;
    col      <= cc;
    value    <= v;
    do @(posedge clk); while (busy);
    absorb_word(kind, int'(rr), int'(cc), v);
    words_sent++;
  endtask

  // write every entry a query at (r, c) will read, so nothing unwritten is used
  task automatic fill_taps(input int r, input int c);
    int ii, jj, kr, kc;
    kr = ker_rows();
    kc = ker_cols();
    for (int mm = 0; mm < kr; mm++) begin
      for (int nn = 0; nn < kc; nn++) begin
        ii = r + kr / 2 - mm;
        jj = c + kc / 2 - nn;
        if (ii >= 0 && ii < img_rows() && jj >= 0 && jj < img_cols()) begin
          if (!weight_known[mm * MAX_KERNEL + nn])
            send_word(REQ_WEIGHT, mm, nn, pick_value());
          if (!pixel_known[ii * MAX_DIM + jj])
            send_word(REQ_PIXEL, ii, jj, pick_value());
        end
      end
    end
  endtask

  task automatic query_at(input int r, input int c);
    fill_taps(r, c);
    send_word(REQ_QUERY, r, c, VAL_W'($urandom));
  endtask

  // let the block go idle: no query outstanding, then the tap-loop latency
  task automatic settle();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMAGE_ROWS:  img_rows_reg = SIZE_W'(data);
      CFG_IMAGE_COLS:  img_cols_reg = SIZE_W'(data);
      CFG_KERNEL_ROWS: ker_rows_reg = KER_W'(data);
      CFG_KERNEL_COLS: ker_cols_reg = KER_W'(data);
      default: ;
    endcase
  endtask

  task automatic set_sizes(input int ir, input int ic, input int kr, input int kc);
    settle();
    write_reg(CFG_IMAGE_ROWS, ir);
    write_reg(CFG_IMAGE_COLS, ic);
    write_reg(CFG_KERNEL_ROWS, kr);
    write_reg(CFG_KERNEL_COLS, kc);
    cfg_valid <= 1'b0;
  endtask

  // reset sizes: 64x64 image, 3x3 kernel; corners, dropped writes, unknown request
  task automatic test_reset_sizes();
    send_word(REQ_WEIGHT, 3, 0, 16'sh7FFF);
    send_word(REQ_WEIGHT, 63, 63, 16'sh8000);
    send_word(REQ_PIXEL, 0, 0, 16'sh8000);
    send_word(REQ_PIXEL, 63, 63, 16'sh7FFF);
    send_word(REQ_WEIGHT, 1, 1, 16'sh8000);
    send_word(REQ_NONE, 42, 21, 16'sh5A5A);
    query_at(0, 0);
    query_at(63, 63);
    query_at(31, 17);
  endtask

  // zero written to every size register acts as 1
  task automatic test_min_sizes();
    set_sizes(0, 0, 0, 0);
    send_word(REQ_PIXEL, 1, 0, 16'sh1234);
    send_word(REQ_PIXEL, 0, 0, 16'shFFFF);
    send_word(REQ_WEIGHT, 0, 1, 16'sh7FFF);
    send_word(REQ_WEIGHT, 0, 0, 16'sh8000);
    query_at(0, 0);
    query_at(63, 63);
    query_at(0, 1);
  endtask

  // image sizes above the maximum act as 64; largest kernel
  task automatic test_max_sizes();
    set_sizes(127, 127, 7, 7);
    send_word(REQ_WEIGHT, 6, 6, 16'sh7FFF);
    send_word(REQ_PIXEL, 63, 0, 16'sh8000);
    query_at(63, 0);
    query_at(0, 63);
  endtask

  task automatic test_random_phase(input int ir, input int ic, input int kr, input int kc,
                                   input int n_words, input bit with_gaps);
    int stop_at, pick, r, c;
    gaps_on = with_gaps;
    set_sizes(ir, ic, kr, kc);
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        if ($urandom_range(3) != 0) begin
          r = $urandom_range(img_rows() - 1);
          c = $urandom_range(img_cols() - 1);
        end else begin
          r = $urandom_range(MAX_DIM - 1);
          c = $urandom_range(MAX_DIM - 1);
        end
        query_at(r, c);
      end else if (pick < 75) begin
        send_word(REQ_PIXEL, $urandom_range(img_rows() - 1), $urandom_range(img_cols() - 1),
                  pick_value());
      end else if (pick < 87) begin
        send_word(REQ_WEIGHT, $urandom_range(ker_rows() - 1), $urandom_range(ker_cols() - 1),
                  pick_value());
      end else if (pick < 95) begin
        // anywhere in the index range; writes outside the sizes in use are dropped
        send_word($urandom_range(1) ? REQ_PIXEL : REQ_WEIGHT, $urandom, $urandom, pick_value());
      end else begin
        send_word(REQ_NONE, $urandom, $urandom, VAL_W'($urandom));
      end
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin : result_check
    conv_word_t want;
    if (!rst && done) begin
      if (pending_sums.size() == 0) begin
        note_mismatch($sformatf("result %0d with no query pending", conv_sum));
      end else begin
        want = pending_sums.pop_front();
        if (conv_sum !== want.sum)
          note_mismatch($sformatf("conv_sum %0d, expected %0d", conv_sum, want.sum));
        if (saturated !== want.sat)
          note_mismatch($sformatf("saturated %b, expected %b", saturated, want.sat));
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = REQ_WEIGHT;
    row          = '0;
    col          = '0;
    value        = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_IMAGE_ROWS;
    cfg_data     = '0;
    img_rows_reg = 7'd64;
    img_cols_reg = 7'd64;
    ker_rows_reg = 3'd3;
    ker_cols_reg = 3'd3;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_sizes();
    test_min_sizes();
    test_max_sizes();
    test_random_phase(3, 5, 2, 4, 180, 1'b1);
    test_random_phase(0, 127, 7, 1, 150, 1'b1);
    test_random_phase(127, 127, 7, 7, 250, 1'b1);
    test_random_phase(64, 64, 3, 3, 250, 1'b0);
    test_random_phase(16, 9, 6, 5, 200, 1'b1);
    test_random_phase(2, 2, 7, 7, 100, 1'b1);
    test_random_phase($urandom_range(1, 20), $urandom_range(1, 20),
                      $urandom_range(0, 7), $urandom_range(0, 7), 200, 1'b1);
    settle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
